@@ src/bbo_pkg.sv @@
// ----------------------------------------------------------------------------
// bbo_pkg: shared types and constants of the box outline overlay
// Field widths, item modes, register indexes, box entry type and the
// Q12.4 to integer edge rounding.
// ----------------------------------------------------------------------------
`default_nettype none

package bbo_pkg;

	localparam int COORD_W   = 16;  // Q12.4 box fields
	localparam int SUM_W     = 18;  // x + w + half without overflow
	localparam int EDGE_W    = 14;  // signed integer box edge
	localparam int POS_W     = 12;  // pixel column / row
	localparam int DIM_W     = 13;  // frame size registers
	localparam int PIX_W     = 8;
	localparam int SLOT_W    = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [SUM_W-1:0]     HALF_Q4          = SUM_W'(8);
	localparam logic [SUM_W-1:0]     TRUNC_BIAS       = SUM_W'(15);
	localparam logic [PIX_W-1:0]     PIX_WHITE        = 8'hFF;
	localparam logic [DIM_W-1:0]     FRAME_WIDTH_RST  = 13'd640;
	localparam logic [DIM_W-1:0]     FRAME_HEIGHT_RST = 13'd480;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_LOAD  = 2'd1,
		MODE_PIXEL = 2'd2
	} mode_t;

	typedef struct packed {
		logic signed [EDGE_W-1:0] left;
		logic signed [EDGE_W-1:0] top;
		logic signed [EDGE_W-1:0] right;
		logic signed [EDGE_W-1:0] bottom;
	} box_t;

	typedef struct packed {
		logic [SLOT_W-1:0]         slot;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] w;
		logic signed [COORD_W-1:0] h;
	} box_load_t;

	// v already holds the half added; divide by 16 truncating toward zero
	function automatic logic signed [EDGE_W-1:0] round_q4(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] adj;
		logic signed [SUM_W-1:0] q;
		adj = v + (v[SUM_W-1] ? TRUNC_BIAS : '0);
		q   = adj >>> 4;
		return q[EDGE_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ src/bounding_box_outline_overlay_top.sv @@
// ----------------------------------------------------------------------------
// bounding_box_outline_overlay_top: box outline overlay on a gray stream
// Holds up to MAX_BOXES boxes and paints their two-pixel outlines white.
// ----------------------------------------------------------------------------
// One beat enters per clock and one result beat leaves per clock while
// out_ready holds high. A beat is captured in the input stage, and from
// there it either updates the box table (clear, load) or runs the compare
// against all boxes in parallel, with the painted pixel landing in the
// output register once that register is free, which raises out_valid.
// The result register decouples the sides, so the input keeps taking
// beats while a result waits, until the input stage itself holds a pixel
// that cannot move. Clear, load and unused mode beats produce no result.
// Box table writes take effect for the very next beat. frame_width and
// frame_height must be written through the cfg port only while the block
// is idle; the block itself does not enforce this. Out-of-frame pixels
// and off-frame boxes are judged against them at pixel time. No clearing
// pass is needed after reset: per-slot valid flags reset directly.
// ----------------------------------------------------------------------------
`default_nettype none

module bounding_box_outline_overlay_top import bbo_pkg::*; #(
	parameter int MAX_BOXES = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// configuration write port
	input  wire logic                       cfg_we,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [DIM_W-1:0]           cfg_data,
	// input channel
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [1:0]                 mode,
	input  wire logic [SLOT_W-1:0]          box_slot,
	input  wire logic signed [COORD_W-1:0]  box_x_pos,
	input  wire logic signed [COORD_W-1:0]  box_y_pos,
	input  wire logic signed [COORD_W-1:0]  box_width,
	input  wire logic signed [COORD_W-1:0]  box_height,
	input  wire logic [POS_W-1:0]           pixel_col,
	input  wire logic [POS_W-1:0]           pixel_row,
	input  wire logic [PIX_W-1:0]           pixel_in,
	// output channel
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [PIX_W-1:0]                pixel_out,
	output logic                            on_border
);

	// configuration registers
	logic [DIM_W-1:0] frame_width_q, frame_height_q;

	// input stage
	logic             valid_s1;
	mode_t            mode_s1;
	box_load_t        load_s1;
	logic [POS_W-1:0] col_s1, row_s1;
	logic [PIX_W-1:0] pix_s1;

	// output stage
	logic             valid_s2;
	logic [PIX_W-1:0] pixel_out_s2;
	logic             on_border_s2;

	logic                 s1_is_pixel, s1_adv, s1_fire, out_free;
	logic                 tbl_clear, tbl_load;
	box_t                 boxes [MAX_BOXES];
	logic [MAX_BOXES-1:0] box_valid;
	logic [MAX_BOXES-1:0] lane_hit;
	logic                 hit_any;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: only a pixel beat can stall, and only on a full output reg
	assign out_free    = !valid_s2 || out_ready;
	assign s1_is_pixel = valid_s1 && (mode_s1 == MODE_PIXEL);
	assign s1_adv      = !s1_is_pixel || out_free;
	assign s1_fire     = valid_s1 && s1_adv;
	assign in_ready    = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1      <= mode_t'(mode);
			load_s1.slot <= box_slot;
			load_s1.x    <= box_x_pos;
			load_s1.y    <= box_y_pos;
			load_s1.w    <= box_width;
			load_s1.h    <= box_height;
			col_s1       <= pixel_col;
			row_s1       <= pixel_row;
			pix_s1       <= pixel_in;
		end
	end

	// mode decode; unused mode is consumed with no effect
	always_comb begin
		tbl_clear = 1'b0;
		tbl_load  = 1'b0;
		if (s1_fire) begin
			unique case (mode_s1)
				MODE_CLEAR: tbl_clear = 1'b1;
				MODE_LOAD:  tbl_load  = 1'b1;
				default: ;
			endcase
		end
	end

	bbo_box_table #(
		.MAX_BOXES (MAX_BOXES)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (tbl_clear),
		.load_en (tbl_load),
		.load    (load_s1),
		.boxes   (boxes),
		.valid   (box_valid)
	);

	// one compare lane per box slot
	for (genvar g = 0; g < MAX_BOXES; g++) begin : g_lane
		bbo_box_hit u_hit (
			.box_valid    (box_valid[g]),
			.box          (boxes[g]),
			.col          (col_s1),
			.row          (row_s1),
			.frame_width  (frame_width_q),
			.frame_height (frame_height_q),
			.hit          (lane_hit[g])
		);
	end

	assign hit_any = |lane_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= s1_is_pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_is_pixel) begin
			pixel_out_s2 <= hit_any ? PIX_WHITE : pix_s1;
			on_border_s2 <= hit_any;
		end
	end

	assign out_valid = valid_s2;
	assign pixel_out = pixel_out_s2;
	assign on_border = on_border_s2;

endmodule

`default_nettype wire

@@ src/bbo_box_table.sv @@
// ----------------------------------------------------------------------------
// bbo_box_table: box entry storage
// Rounds a loaded Q12.4 box to integer edges and keeps one entry per slot
// with a valid flag; clear drops all flags.
// ----------------------------------------------------------------------------
`default_nettype none

module bbo_box_table import bbo_pkg::*; #(
	parameter int MAX_BOXES = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 clear,
	input  wire logic                 load_en,
	input  wire box_load_t            load,
	output box_t                      boxes [MAX_BOXES],
	output logic [MAX_BOXES-1:0]      valid
);

	logic signed [SUM_W-1:0] x_ext, y_ext, w_ext, h_ext;
	logic signed [SUM_W-1:0] left_sum, top_sum, right_sum, bottom_sum;
	box_t                    new_box;
	box_t                    boxes_q [MAX_BOXES];
	logic [MAX_BOXES-1:0]    valid_q;

	assign x_ext = {{(SUM_W-COORD_W){load.x[COORD_W-1]}}, load.x};
	assign y_ext = {{(SUM_W-COORD_W){load.y[COORD_W-1]}}, load.y};
	assign w_ext = {{(SUM_W-COORD_W){load.w[COORD_W-1]}}, load.w};
	assign h_ext = {{(SUM_W-COORD_W){load.h[COORD_W-1]}}, load.h};

	assign left_sum   = x_ext + HALF_Q4;
	assign top_sum    = y_ext + HALF_Q4;
	assign right_sum  = x_ext + w_ext + HALF_Q4;
	assign bottom_sum = y_ext + h_ext + HALF_Q4;

	always_comb begin
		new_box.left   = round_q4(left_sum);
		new_box.top    = round_q4(top_sum);
		new_box.right  = round_q4(right_sum) - EDGE_W'(1);
		new_box.bottom = round_q4(bottom_sum) - EDGE_W'(1);
	end

	// slots at or above MAX_BOXES match no entry and are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (load_en) begin
			for (int i = 0; i < MAX_BOXES; i++) begin
				if (int'(load.slot) == i) begin
					valid_q[i] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_BOXES; i++) begin
			if (load_en && int'(load.slot) == i) begin
				boxes_q[i] <= new_box;
			end
		end
	end

	assign boxes = boxes_q;
	assign valid = valid_q;

endmodule

`default_nettype wire

@@ src/bbo_box_hit.sv @@
// ----------------------------------------------------------------------------
// bbo_box_hit: outline test of one box
// Flags a pixel on the two-pixel outline of one stored box, clipped to
// the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module bbo_box_hit import bbo_pkg::*; (
	input  wire logic             box_valid,
	input  wire box_t             box,
	input  wire logic [POS_W-1:0] col,
	input  wire logic [POS_W-1:0] row,
	input  wire logic [DIM_W-1:0] frame_width,
	input  wire logic [DIM_W-1:0] frame_height,
	output logic                  hit
);

	localparam int CMP_W = EDGE_W + 1;
	localparam logic signed [CMP_W-1:0] ONE  = CMP_W'(1);
	localparam logic signed [CMP_W-1:0] ZERO = '0;

	logic signed [CMP_W-1:0] c, r, fw, fh, l, t, rt, b;
	logic in_frame, off_frame, in_col, in_row, on_hline, on_vline;

	assign c  = {{(CMP_W-POS_W){1'b0}}, col};
	assign r  = {{(CMP_W-POS_W){1'b0}}, row};
	assign fw = {{(CMP_W-DIM_W){1'b0}}, frame_width};
	assign fh = {{(CMP_W-DIM_W){1'b0}}, frame_height};
	assign l  = {box.left[EDGE_W-1], box.left};
	assign t  = {box.top[EDGE_W-1], box.top};
	assign rt = {box.right[EDGE_W-1], box.right};
	assign b  = {box.bottom[EDGE_W-1], box.bottom};

	assign in_frame  = (c < fw) && (r < fh);
	assign off_frame = (rt < ZERO) || (b < ZERO) || (l >= fw) || (t >= fh);

	// with the pixel inside the frame and the box not off-frame, clamping
	// the spans to the frame changes nothing
	assign in_col   = (c >= l) && (c <= rt);
	assign in_row   = (r >= t) && (r <= b);
	assign on_hline = (r == t) || (r == t + ONE) || (r == b) || (r == b - ONE);
	assign on_vline = (c == l) || (c == l + ONE) || (c == rt) || (c == rt - ONE);

	assign hit = box_valid && in_frame && !off_frame &&
		((in_col && on_hline) || (in_row && on_vline));

endmodule

`default_nettype wire

@@ src/bbo_checker.sv @@
// ----------------------------------------------------------------------------
// bbo_checker: port-level checks of the box outline overlay
// Watches the top level ports; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module bbo_checker import bbo_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic [1:0]       mode,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [PIX_W-1:0] pixel_out,
	input wire logic             on_border
);

	// a waiting result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(on_border))
		else $error("result beat changed while stalled");

	// border pixels are painted white
	a_border_white: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && on_border |-> pixel_out == PIX_WHITE)
		else $error("border pixel not white");

	// input only stalls behind a pending result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// an accepted pixel leaves a result pending once past the input stage and output register
	a_pixel_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == MODE_PIXEL |-> ##2 out_valid)
		else $error("pixel beat produced no result");

endmodule

bind bounding_box_outline_overlay_top bbo_checker u_bbo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.mode      (mode),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.pixel_out (pixel_out),
	.on_border (on_border)
);

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: box outline overlay, self-checking
// Drives clear, load, pixel and spare-mode beats through the valid/ready
// input, keeps a shadow box table and frame size, and checks every painted
// pixel against the shadow. Directed geometry, rounding and frame cases come
// first, then random traffic under three idling regimes and a long output
// stall that backs the block up.
// ----------------------------------------------------------------------------

module testbench;
	import bbo_pkg::*;

	localparam int NUM_SLOTS    = 8;
	localparam int HALF_PX_Q4   = 8;        // one half in Q12.4
	localparam int OUTLINE_T    = 2;        // outline thickness
	localparam int DRAIN_CYCLES = 8;        // margin for the pipe to drain
	localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PRINT_CAP    = 30;
	localparam logic [1:0] MODE_SPARE = 2'd3;   // unused mode code

	// one expected painted pixel; col/row kept for the report only
	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic             border;
		int               col;
		int               row;
	} painted_t;

	// ------------------------------------------------------------------
	// DUT signals
	// ------------------------------------------------------------------
	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [DIM_W-1:0]          cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic [1:0]                mode;
	logic [SLOT_W-1:0]         box_slot;
	logic signed [COORD_W-1:0] box_x_pos;
	logic signed [COORD_W-1:0] box_y_pos;
	logic signed [COORD_W-1:0] box_width;
	logic signed [COORD_W-1:0] box_height;
	logic [POS_W-1:0]          pixel_col;
	logic [POS_W-1:0]          pixel_row;
	logic [PIX_W-1:0]          pixel_in;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [PIX_W-1:0]          pixel_out;
	logic                      on_border;

	bounding_box_outline_overlay_top #(.MAX_BOXES(NUM_SLOTS)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.box_slot   (box_slot),
		.box_x_pos  (box_x_pos),
		.box_y_pos  (box_y_pos),
		.box_width  (box_width),
		.box_height (box_height),
		.pixel_col  (pixel_col),
		.pixel_row  (pixel_row),
		.pixel_in   (pixel_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.on_border  (on_border)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow state: box table and frame size as the block should hold them
	// ------------------------------------------------------------------
	logic signed [EDGE_W-1:0] shadow_left   [NUM_SLOTS];
	logic signed [EDGE_W-1:0] shadow_top    [NUM_SLOTS];
	logic signed [EDGE_W-1:0] shadow_right  [NUM_SLOTS];
	logic signed [EDGE_W-1:0] shadow_bottom [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]     shadow_valid;
	int                       shadow_fw;
	int                       shadow_fh;

	painted_t painted_q[$];     // pixels still owed by the block

	int errors         = 0;
	int beats_sent     = 0;
	int pixels_checked = 0;
	int border_hits    = 0;
	int frame_settings = 0;
	int cycle_count    = 0;

	// idling knobs, percent of cycles
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit stall_request = 1'b0;
	int stall_left    = 0;

	// window the random boxes and pixels crowd around
	int win_x0, win_y0, win_w, win_h;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	// Q12.4 plus a half, truncated toward zero (int division does that)
	function automatic int nearest_px(int q);
		return (q + HALF_PX_Q4) / 16;
	endfunction

	// horizontal outline run on line y, span [a, b] clamped to the line
	function automatic bit on_hrun(int c, int r, int a, int b, int y);
		if (y < 0 || y >= shadow_fh || r != y)
			return 1'b0;
		a = (a < 0) ? 0 : ((a > shadow_fw - 1) ? shadow_fw - 1 : a);
		b = (b < 0) ? 0 : ((b > shadow_fw - 1) ? shadow_fw - 1 : b);
		return b >= a && c >= a && c <= b;
	endfunction

	// vertical outline run on column x, span [a, b] clamped to the frame
	function automatic bit on_vrun(int c, int r, int x, int a, int b);
		if (x < 0 || x >= shadow_fw || c != x)
			return 1'b0;
		a = (a < 0) ? 0 : ((a > shadow_fh - 1) ? shadow_fh - 1 : a);
		b = (b < 0) ? 0 : ((b > shadow_fh - 1) ? shadow_fh - 1 : b);
		return b >= a && r >= a && r <= b;
	endfunction

	function automatic bit outline_hit(int c, int r);
		bit hit;
		int l, tp, rt, bt;
		hit = 1'b0;
		if (c >= shadow_fw || r >= shadow_fh)
			return 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			l  = shadow_left[i];
			tp = shadow_top[i];
			rt = shadow_right[i];
			bt = shadow_bottom[i];
			if (!shadow_valid[i])
				continue;
			// off-frame boxes are judged against the current frame size
			if (rt < 0 || bt < 0 || l >= shadow_fw || tp >= shadow_fh)
				continue;
			for (int t = 0; t < OUTLINE_T; t++) begin
				if (on_hrun(c, r, l, rt, tp + t) || on_hrun(c, r, l, rt, bt - t) ||
				    on_vrun(c, r, l + t, tp, bt) || on_vrun(c, r, rt - t, tp, bt))
					hit = 1'b1;
			end
		end
		return hit;
	endfunction

	// apply one accepted beat to the shadow; pixels queue a painted result
	task automatic track_beat(input logic [1:0] m, input logic [SLOT_W-1:0] slot,
	                          input logic signed [COORD_W-1:0] x, y, w, h,
	                          input logic [POS_W-1:0] col, row, input logic [PIX_W-1:0] pix);
		painted_t e;
		case (m)
			MODE_CLEAR: begin
				// edges stay, only the flags drop
				shadow_valid = '0;
			end
			MODE_LOAD: begin
				if (slot < NUM_SLOTS) begin
					shadow_left[slot]   = EDGE_W'(nearest_px(int'(x)));
					shadow_top[slot]    = EDGE_W'(nearest_px(int'(y)));
					shadow_right[slot]  = EDGE_W'(nearest_px(int'(x) + int'(w)) - 1);
					shadow_bottom[slot] = EDGE_W'(nearest_px(int'(y) + int'(h)) - 1);
					shadow_valid[slot]  = 1'b1;
				end
			end
			MODE_PIXEL: begin
				e.col    = int'(col);
				e.row    = int'(row);
				e.border = outline_hit(e.col, e.row);
				e.pixel  = e.border ? PIX_WHITE : pix;
				painted_q.push_back(e);
			end
			default: ;  // spare mode: nothing happens
		endcase
	endtask

	// ------------------------------------------------------------------
	// Sender: one beat, held until the handshake
	// ------------------------------------------------------------------
	task automatic send_beat(input logic [1:0] m, input logic [SLOT_W-1:0] slot,
	                         input logic signed [COORD_W-1:0] x, y, w, h,
	                         input logic [POS_W-1:0] col, row, input logic [PIX_W-1:0] pix);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		box_slot   <= slot;
		box_x_pos  <= x;
		box_y_pos  <= y;
		box_width  <= w;
		box_height <= h;
		pixel_col  <= col;
		pixel_row  <= row;
		pixel_in   <= pix;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		track_beat(m, slot, x, y, w, h, col, row, pix);
		beats_sent++;
	endtask

	// fields a beat does not use carry random noise
	task automatic send_load(input logic [SLOT_W-1:0] slot,
	                         input logic signed [COORD_W-1:0] x, y, w, h);
		send_beat(MODE_LOAD, slot, x, y, w, h,
		          POS_W'($urandom), POS_W'($urandom), PIX_W'($urandom));
	endtask

	task automatic send_pixel(input logic [POS_W-1:0] col, row, input logic [PIX_W-1:0] pix);
		send_beat(MODE_PIXEL, SLOT_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
		          COORD_W'($urandom), COORD_W'($urandom), col, row, pix);
	endtask

	task automatic send_op(input logic [1:0] m);
		send_beat(m, SLOT_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
		          COORD_W'($urandom), COORD_W'($urandom),
		          POS_W'($urandom), POS_W'($urandom), PIX_W'($urandom));
	endtask

	// ------------------------------------------------------------------
	// Frame size writes, only with the pipe drained
	// ------------------------------------------------------------------
	task automatic set_frame(input int fw, input int fh);
		in_valid <= 1'b0;
		while (painted_q.size() != 0)
			@(posedge clk);
		// loads and clears leave no result; let them clear the pipe too
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_FRAME_WIDTH;
		cfg_data  <= DIM_W'(fw);
		@(posedge clk);
		cfg_index <= CFG_FRAME_HEIGHT;
		cfg_data  <= DIM_W'(fh);
		@(posedge clk);
		cfg_we    <= 1'b0;
		shadow_fw = fw & 32'h1FFF;
		shadow_fh = fh & 32'h1FFF;
		frame_settings++;
		// random window: near the origin, or near the far edge of big frames
		win_w  = (shadow_fw < 40) ? shadow_fw : 40;
		win_h  = (shadow_fh < 40) ? shadow_fh : 40;
		win_x0 = (shadow_fw > 80 && $urandom_range(1)) ?
		         ((shadow_fw > 2040) ? 2040 : shadow_fw) - 40 : 0;
		win_y0 = (shadow_fh > 80 && $urandom_range(1)) ?
		         ((shadow_fh > 2040) ? 2040 : shadow_fh) - 40 : 0;
	endtask

	// box with random fraction straddling the window; widths may go negative
	task automatic load_near();
		int x, y, w, h, r;
		r = $urandom_range(win_w + 8);
		x = (win_x0 + r - 4) * 16 + $urandom_range(15);
		r = $urandom_range(win_h + 8);
		y = (win_y0 + r - 4) * 16 + $urandom_range(15);
		r = $urandom_range(win_w + 4);
		w = (r - 1) * 16 + $urandom_range(15);
		r = $urandom_range(win_h + 4);
		h = (r - 1) * 16 + $urandom_range(15);
		send_load(SLOT_W'($urandom), COORD_W'(x), COORD_W'(y), COORD_W'(w), COORD_W'(h));
	endtask

	task automatic pixel_near();
		int c, r;
		c = win_x0 + $urandom_range(win_w + 5);
		r = win_y0 + $urandom_range(win_h + 5);
		c = (c < 2) ? 0 : ((c - 2 > 4095) ? 4095 : c - 2);
		r = (r < 2) ? 0 : ((r - 2 > 4095) ? 4095 : r - 2);
		send_pixel(POS_W'(c), POS_W'(r), PIX_W'($urandom));
	endtask

	// mostly pixels around the boxes, some loads, clears and noise
	task automatic random_beat();
		int k;
		k = $urandom_range(99);
		if (k < 10)
			load_near();
		else if (k < 12)
			send_op(MODE_CLEAR);
		else if (k < 14)
			send_op(MODE_SPARE);
		else if (k < 17)
			send_load(SLOT_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
			          COORD_W'($urandom), COORD_W'($urandom));
		else if (k < 20)
			send_pixel(POS_W'($urandom), POS_W'($urandom), PIX_W'($urandom));
		else
			pixel_near();
	endtask

	// ------------------------------------------------------------------
	// Receiver and result check
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_request) begin
			stall_left    = HOLD_CYCLES;
			stall_request = 1'b0;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		painted_t e;
		if (arst_n && out_valid && out_ready) begin
			if (painted_q.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing owed, pixel %0d border %0d",
				                          pixel_out, on_border));
			end else begin
				e = painted_q.pop_front();
				pixels_checked++;
				if (e.border)
					border_hits++;
				if (pixel_out !== e.pixel)
					report_mismatch($sformatf("pixel_out at (%0d,%0d): got %0d want %0d",
					                          e.col, e.row, pixel_out, e.pixel));
				if (on_border !== e.border)
					report_mismatch($sformatf("on_border at (%0d,%0d): got %0d want %0d",
					                          e.col, e.row, on_border, e.border));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed",
			         cycle_count, painted_q.size());
			$display("testbench: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// plain 10x10 box at the origin under the reset frame size
	task automatic test_outline_geometry();
		send_pixel(12'd0, 12'd0, 8'h5A);        // empty table: passes
		send_load(3'd0, 16'sd0, 16'sd0, 16'sd160, 16'sd160);    // edges 0..9
		send_pixel(12'd0, 12'd5, 8'h11);        // left column
		send_pixel(12'd1, 12'd5, 8'h22);        // second left column
		send_pixel(12'd2, 12'd5, 8'h33);        // inside
		send_pixel(12'd5, 12'd8, 8'h44);        // second bottom line
		send_pixel(12'd5, 12'd9, 8'h55);        // bottom line
		send_pixel(12'd10, 12'd9, 8'h66);       // just past the right edge
	endtask

	// negative positions truncate toward zero, not down
	task automatic test_rounding();
		send_load(3'd1, -16'sd24, -16'sd20, 16'sd104, 16'sd100);  // l -1, t 0, r 4, b 4
		send_pixel(12'd4, 12'd2, 8'h77);
		send_pixel(12'd3, 12'd3, 8'h88);
	endtask

	// full-scale fields: boxes off-frame on either side, pixel at the top code
	task automatic test_field_extremes();
		send_load(3'd7, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
		send_load(3'd6, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
		send_pixel(12'hFFF, 12'hFFF, 8'hFF);    // outside the frame
		send_pixel(12'd639, 12'd479, 8'h00);
	endtask

	task automatic test_clear_and_spare();
		send_op(MODE_SPARE);                    // no effect, no result
		send_pixel(12'd0, 12'd5, 8'h00);        // still on the slot 0 outline
		send_op(MODE_CLEAR);
		send_pixel(12'd0, 12'd5, 8'h00);        // table empty now
	endtask

	task automatic test_frame_settings();
		set_frame(0, 480);                      // zero width: nothing in frame
		send_load(3'd0, 16'sd0, 16'sd0, 16'sd160, 16'sd160);
		send_pixel(12'd0, 12'd0, 8'h12);
		set_frame(1, 1);
		send_pixel(12'd0, 12'd0, 8'h34);        // top line clamped to one pixel
		set_frame(8191, 8191);
		send_load(3'd2, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);  // 2048..4095
		send_pixel(12'd4095, 12'd3000, 8'h56);
		set_frame(4096, 4096);
		send_pixel(12'd4095, 12'd4095, 8'h78);
	endtask

	// three idling regimes, three frame settings each, boxes first per phase
	task automatic test_random_traffic();
		int fw, fh;
		for (int regime = 0; regime < 3; regime++) begin
			send_idle_pct = (regime == 0) ? 7 : ((regime == 1) ? 83 : 0);
			recv_idle_pct = (regime == 0) ? 83 : ((regime == 1) ? 7 : 0);
			for (int phase = 0; phase < 3; phase++) begin
				case ($urandom_range(9))
					0: begin fw = 24;   fh = 16;   end
					1: begin fw = 7;    fh = 5;    end
					2: begin fw = 1;    fh = 1;    end
					3: begin fw = 0;    fh = 12;   end
					4: begin fw = 16;   fh = 0;    end
					5: begin fw = 640;  fh = 480;  end
					6: begin fw = 4096; fh = 4096; end
					7: begin fw = 8191; fh = 3;    end
					8: begin fw = 40;   fh = 40;   end
					default: begin fw = 2; fh = 300; end
				endcase
				set_frame(fw, fh);
				if ($urandom_range(1))
					send_op(MODE_CLEAR);
				repeat ($urandom_range(4, 2)) load_near();
				repeat (52) random_beat();
			end
		end
	endtask

	// receiver holds off while the sender keeps offering pixels
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_frame(24, 16);
		load_near();
		load_near();
		stall_request = 1'b1;
		repeat (40) pixel_near();
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		mode       = MODE_CLEAR;
		box_slot   = '0;
		box_x_pos  = '0;
		box_y_pos  = '0;
		box_width  = '0;
		box_height = '0;
		pixel_col  = '0;
		pixel_row  = '0;
		pixel_in   = '0;
		shadow_fw  = int'(FRAME_WIDTH_RST);
		shadow_fh  = int'(FRAME_HEIGHT_RST);
		shadow_valid = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			shadow_left[i]   = '0;
			shadow_top[i]    = '0;
			shadow_right[i]  = '0;
			shadow_bottom[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part runs with a slow receiver
		send_idle_pct = 7;
		recv_idle_pct = 83;
		test_outline_geometry();
		test_rounding();
		test_field_extremes();
		test_clear_and_spare();
		test_frame_settings();
		test_random_traffic();
		test_backpressure();

		in_valid <= 1'b0;
		while (painted_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d input beats over %0d frame settings",
		         beats_sent, frame_settings);
		$display("%0d painted pixels checked, %0d of them on an outline",
		         pixels_checked, border_hits);
		if (errors == 0 && painted_q.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
